// ----- src/dnle_pkg.sv -----
// Shared types and constants for the DNS name label encoder.
package dnle_pkg;

  localparam int BYTE_W = 8;
  localparam logic [BYTE_W-1:0] DOT_CHAR = 8'd46;

  typedef enum logic [1:0] {
    K_LEN,
    K_CHAR,
    K_EMPTY,
    K_TERM
  } emit_kind_t;

  typedef struct packed {
    logic       store;
    logic       clr;
    logic       emit;
    emit_kind_t kind;
    logic       adv;
  } dp_cmd_t;

  typedef struct packed {
    logic is_dot;
    logic label_full;
    logic label_empty;
    logic idx_last;
    logic out_free;
  } dp_sts_t;

endpackage

// ----- src/dns_name_label_encoder.sv -----
// Top level: DNS name to wire-format label encoder.
//
//   channel  signals                                      direction
//   src      src_valid, src_ready, ch, final_char         characters in
//   dst      dst_valid, dst_ready, out_byte, is_length,   wire words out
//            name_done, overflow
//
// A character that ends no label is taken with one store write. A flushing
// character is followed by its output words in order: length, each stored
// character (read from the label store's single read port), and an empty
// label and terminator where they apply. A stalled output holds the
// sequencer in place. Reset is synchronous; the label store needs no clear.
module dns_name_label_encoder #(
  parameter int LABEL_MAX = 62
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       src_valid,
  output logic       src_ready,
  input  logic [7:0] ch,
  input  logic       final_char,
  output logic       dst_valid,
  input  logic       dst_ready,
  output logic [7:0] out_byte,
  output logic       is_length,
  output logic       name_done,
  output logic       overflow
);

  dnle_pkg::dp_cmd_t cmd;
  dnle_pkg::dp_sts_t sts;

  dnle_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .src_valid  (src_valid),
    .src_ready  (src_ready),
    .final_char (final_char),
    .sts        (sts),
    .cmd        (cmd)
  );

  dnle_datapath #(
    .LABEL_MAX (LABEL_MAX)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ch        (ch),
    .cmd       (cmd),
    .sts       (sts),
    .dst_ready (dst_ready),
    .dst_valid (dst_valid),
    .out_byte  (out_byte),
    .is_length (is_length),
    .name_done (name_done),
    .overflow  (overflow)
  );

endmodule

// ----- src/dnle_datapath.sv -----
// Datapath: label store, label count, overflow flag and output word register.
module dnle_datapath #(
  parameter int LABEL_MAX = 62
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [dnle_pkg::BYTE_W-1:0]  ch,
  input  dnle_pkg::dp_cmd_t            cmd,
  output dnle_pkg::dp_sts_t            sts,
  input  logic                         dst_ready,
  output logic                         dst_valid,
  output logic [dnle_pkg::BYTE_W-1:0]  out_byte,
  output logic                         is_length,
  output logic                         name_done,
  output logic                         overflow
);

  localparam int AW = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;
  localparam int CW = $clog2(LABEL_MAX + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(LABEL_MAX);

  logic [dnle_pkg::BYTE_W-1:0] mem [LABEL_MAX];
  logic [dnle_pkg::BYTE_W-1:0] rd_data;
  logic [CW-1:0]               count;
  logic                        lost;
  logic [AW-1:0]               idx;
  logic [AW-1:0]               idx_next;
  logic                        room;

  assign room = (count < CNT_MAX);

  always_comb begin
    sts.is_dot      = (ch == dnle_pkg::DOT_CHAR);
    sts.label_full  = !room;
    sts.label_empty = (count == '0);
    sts.idx_last    = (CW'(idx) == count - CW'(1));
    sts.out_free    = !dst_valid || dst_ready;
  end

  always_comb begin
    idx_next = idx;
    if (cmd.adv) begin
      idx_next = sts.idx_last ? '0 : idx + AW'(1);
    end
  end

  // label store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.store && room) begin
      mem[count[AW-1:0]] <= ch;
    end
    rd_data <= mem[idx_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      lost  <= 1'b0;
      idx   <= '0;
    end else begin
      idx <= idx_next;
      if (cmd.clr) begin
        count <= '0;
        lost  <= 1'b0;
      end else if (cmd.store) begin
        if (room) begin
          count <= count + CW'(1);
        end else begin
          lost <= 1'b1;
        end
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (cmd.emit) begin
      dst_valid <= 1'b1;
    end else if (dst_ready) begin
      dst_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.kind)
        dnle_pkg::K_LEN: begin
          out_byte  <= dnle_pkg::BYTE_W'(count);
          is_length <= 1'b1;
          name_done <= 1'b0;
          overflow  <= lost;
        end
        dnle_pkg::K_CHAR: begin
          out_byte  <= rd_data;
          is_length <= 1'b0;
          name_done <= 1'b0;
          overflow  <= lost;
        end
        dnle_pkg::K_EMPTY: begin
          out_byte  <= '0;
          is_length <= 1'b1;
          name_done <= 1'b0;
          overflow  <= 1'b0;
        end
        default: begin
          out_byte  <= '0;
          is_length <= 1'b1;
          name_done <= 1'b1;
          overflow  <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ----- src/dnle_ctrl.sv -----
// Controller: sequences length, label, empty label and terminator words.
module dnle_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  output logic              src_ready,
  input  logic              final_char,
  input  dnle_pkg::dp_sts_t sts,
  output dnle_pkg::dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEN,
    S_DATA,
    S_EMPTY,
    S_TERM
  } state_t;

  state_t state;
  state_t state_next;
  logic   want_empty;
  logic   want_empty_next;
  logic   want_term;
  logic   want_term_next;
  state_t after_label;

  assign src_ready = (state == S_IDLE);

  always_comb begin
    if (want_empty) begin
      after_label = S_EMPTY;
    end else if (want_term) begin
      after_label = S_TERM;
    end else begin
      after_label = S_IDLE;
    end
  end

  always_comb begin
    state_next      = state;
    want_empty_next = want_empty;
    want_term_next  = want_term;
    cmd.store = 1'b0;
    cmd.clr   = 1'b0;
    cmd.emit  = 1'b0;
    cmd.kind  = dnle_pkg::K_LEN;
    cmd.adv   = 1'b0;
    case (state)
      S_IDLE: begin
        if (src_valid) begin
          if (sts.is_dot) begin
            state_next      = S_LEN;
            want_empty_next = final_char && !sts.label_full;
            want_term_next  = final_char;
          end else begin
            cmd.store = 1'b1;
            if (final_char) begin
              state_next      = S_LEN;
              want_empty_next = 1'b0;
              want_term_next  = 1'b1;
            end
          end
        end
      end
      S_LEN: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = dnle_pkg::K_LEN;
          if (sts.label_empty) begin
            cmd.clr    = 1'b1;
            state_next = after_label;
          end else begin
            state_next = S_DATA;
          end
        end
      end
      S_DATA: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = dnle_pkg::K_CHAR;
          cmd.adv  = 1'b1;
          if (sts.idx_last) begin
            cmd.clr    = 1'b1;
            state_next = after_label;
          end
        end
      end
      S_EMPTY: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = dnle_pkg::K_EMPTY;
          state_next = S_TERM;
        end
      end
      S_TERM: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = dnle_pkg::K_TERM;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      want_empty <= 1'b0;
      want_term  <= 1'b0;
    end else begin
      state      <= state_next;
      want_empty <= want_empty_next;
      want_term  <= want_term_next;
    end
  end

endmodule

// ----- verif/dnle_checker.sv -----
// Checker for the DNS name label encoder: predicts wire words and compares them.
module dnle_checker #(
  parameter int LABEL_MAX = 62
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       src_valid,
  input  logic       src_ready,
  input  logic [7:0] ch,
  input  logic       final_char,
  input  logic       dst_valid,
  input  logic       dst_ready,
  input  logic [7:0] out_byte,
  input  logic       is_length,
  input  logic       name_done,
  input  logic       overflow,
  output int         mismatches,
  output int         words_pending
);

  typedef struct packed {
    logic [7:0] b;
    logic       len;
    logic       done;
    logic       ovf;
  } wire_word_t;

  wire_word_t wire_q[$];
  logic [7:0] held[LABEL_MAX];
  int         held_n;
  bit         dropped;
  int         err_cnt;

  function automatic void push_word(input logic [7:0] b, input logic len,
                                    input logic done, input logic ovf);
    wire_word_t w;
    w.b    = b;
    w.len  = len;
    w.done = done;
    w.ovf  = ovf;
    wire_q.push_back(w);
  endfunction

  function automatic void flush_label();
    push_word(8'(held_n), 1'b1, 1'b0, dropped);
    for (int k = 0; k < held_n; k++)
      push_word(held[k], 1'b0, 1'b0, dropped);
    held_n  = 0;
    dropped = 1'b0;
  endfunction

  function automatic void encode_char(input logic [7:0] c, input logic fin);
    bit full;
    if (c == dnle_pkg::DOT_CHAR) begin
      full = (held_n >= LABEL_MAX);
      flush_label();
      if (fin) begin
        // a final dot adds an empty label unless the label was full
        if (!full) push_word(8'd0, 1'b1, 1'b0, 1'b0);
        push_word(8'd0, 1'b1, 1'b1, 1'b0);
      end
    end else begin
      if (held_n < LABEL_MAX) begin
        held[held_n] = c;
        held_n++;
      end else begin
        dropped = 1'b1;
      end
      if (fin) begin
        flush_label();
        push_word(8'd0, 1'b1, 1'b1, 1'b0);
      end
    end
  endfunction

  function automatic void check_field(input string fname, input logic [7:0] e,
                                      input logic [7:0] g);
    if (g !== e) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, e, g);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    wire_word_t w;
    if (rst) begin
      wire_q.delete();
      held_n  = 0;
      dropped = 1'b0;
    end else begin
      if (dst_valid && dst_ready) begin
        if (wire_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %0h len %b done %b ovf %b",
                   $time, out_byte, is_length, name_done, overflow);
          err_cnt++;
        end else begin
          w = wire_q.pop_front();
          check_field("out_byte", w.b, out_byte);
          check_field("is_length", 8'(w.len), 8'(is_length));
          check_field("name_done", 8'(w.done), 8'(name_done));
          check_field("overflow", 8'(w.ovf), 8'(overflow));
        end
      end
      if (src_valid && src_ready) encode_char(ch, final_char);
    end
    mismatches    <= err_cnt;
    words_pending <= wire_q.size();
  end

endmodule

// ----- verif/testbench.sv -----
// Testbench top for the DNS name label encoder: stimulus, receiver stalls, verdict.
module testbench;

  localparam int LABEL_MAX = 62;

  logic       clk;
  logic       rst = 1'b1;
  logic       src_valid = 1'b0;
  logic       src_ready;
  logic [7:0] ch = 8'd0;
  logic       final_char = 1'b0;
  logic       dst_valid;
  logic       dst_ready = 1'b0;
  logic [7:0] out_byte;
  logic       is_length;
  logic       name_done;
  logic       overflow;

  int mismatches;
  int words_pending;

  int burst_left = 0;
  int chars_sent = 0;

  logic hold_req  = 1'b0;
  bit   hold_used = 1'b0;
  int   hold_left = 0;
  int   rx_mode   = 0;
  int   mode_left = 0;

  dns_name_label_encoder #(.LABEL_MAX(LABEL_MAX)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .ch        (ch),
    .final_char(final_char),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .out_byte  (out_byte),
    .is_length (is_length),
    .name_done (name_done),
    .overflow  (overflow)
  );

  dnle_checker #(.LABEL_MAX(LABEL_MAX)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .src_valid    (src_valid),
    .src_ready    (src_ready),
    .ch           (ch),
    .final_char   (final_char),
    .dst_valid    (dst_valid),
    .dst_ready    (dst_ready),
    .out_byte     (out_byte),
    .is_length    (is_length),
    .name_done    (name_done),
    .overflow     (overflow),
    .mismatches   (mismatches),
    .words_pending(words_pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #8000000;
    $display("dns_name_label_encoder test failed");
    $finish;
  end

  // receiver: one long hold-off on request, otherwise shifting stall modes
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      dst_ready <= 1'b0;
    end else if (hold_req && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= 400;
      dst_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= $urandom_range(0, 3);
        mode_left <= $urandom_range(10, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        0: dst_ready <= 1'b1;
        1: dst_ready <= 1'($urandom_range(0, 1));
        2: dst_ready <= ($urandom_range(0, 3) == 0);
        default: dst_ready <= ~dst_ready;
      endcase
    end
  end

  task automatic send_char(input logic [7:0] c, input logic fin);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        src_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    src_valid  <= 1'b1;
    ch         <= c;
    final_char <= fin;
    do @(posedge clk); while (!src_ready);
    chars_sent++;
  endtask

  function automatic logic [7:0] label_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == dnle_pkg::DOT_CHAR);
    return c;
  endfunction

  function automatic int pick_len();
    if ($urandom_range(0, 11) == 0) return $urandom_range(58, 66);
    return $urandom_range(0, 8);
  endfunction

  task automatic send_label(input int len, input logic fin_last);
    int k;
    for (k = 0; k < len; k++)
      send_char(label_char(), fin_last && (k == len - 1));
  endtask

  task automatic send_name();
    int  n_labels;
    int  len;
    int  i;
    bit  dot_end;
    n_labels = $urandom_range(1, 4);
    dot_end  = ($urandom_range(0, 3) == 0);
    for (i = 0; i < n_labels; i++) begin
      len = pick_len();
      if (i == n_labels - 1 && !dot_end && len == 0) len = 1;
      send_label(len, (i == n_labels - 1) && !dot_end);
      if (i < n_labels - 1 || dot_end) send_char(dnle_pkg::DOT_CHAR, i == n_labels - 1);
    end
  endtask

  task automatic send_noise();
    int n;
    int k;
    n = $urandom_range(1, 6);
    for (k = 0; k < n; k++)
      send_char(($urandom_range(0, 3) == 0) ? dnle_pkg::DOT_CHAR :
                8'($urandom_range(0, 255)),
                $urandom_range(0, 3) == 0);
  endtask

  task automatic wait_drained();
    int waited;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (words_pending != 0 && waited < 20000);
  endtask

  initial begin
    int rand_end;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // short names: lone final dot, byte extremes, empty labels, final dots
    send_char(dnle_pkg::DOT_CHAR, 1'b1);
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    send_char(8'h61, 1'b0);
    send_char(dnle_pkg::DOT_CHAR, 1'b0);
    send_char(8'h62, 1'b1);
    send_char(8'h61, 1'b0);
    send_char(dnle_pkg::DOT_CHAR, 1'b1);
    send_char(dnle_pkg::DOT_CHAR, 1'b0);
    send_char(dnle_pkg::DOT_CHAR, 1'b0);
    send_char(8'h78, 1'b1);
    send_char(8'h61, 1'b0);
    send_char(8'h62, 1'b0);
    send_char(dnle_pkg::DOT_CHAR, 1'b0);
    send_char(dnle_pkg::DOT_CHAR, 1'b1);
    send_char(8'h2D, 1'b1);
    send_char(8'h2F, 1'b1);
    send_char(8'h80, 1'b0);
    send_char(8'h7F, 1'b1);

    // full label ending in a final dot, then an overflowing final label,
    // while the receiver holds off
    send_label(LABEL_MAX, 1'b0);
    hold_req <= 1'b1;
    send_char(dnle_pkg::DOT_CHAR, 1'b1);
    send_label(LABEL_MAX + 2, 1'b1);

    src_valid <= 1'b0;
    wait_drained();

    rand_end = 360;
    while (chars_sent < rand_end) begin
      if ($urandom_range(0, 7) == 0) send_noise();
      else send_name();
    end
    src_valid <= 1'b0;

    wait_drained();
    repeat (50) @(posedge clk);
    if (words_pending != 0)
      $display("%0t: %0d expected words never arrived", $time, words_pending);
    if (mismatches == 0 && words_pending == 0)
      $display("dns_name_label_encoder test passed");
    else
      $display("dns_name_label_encoder test failed");
    $finish;
  end

endmodule
